### design/slev_pkg.sv
`timescale 1ns / 1ps

package slev_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_SEND
	} state_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	localparam logic CFG_SPRITE_TALL          = 1'b0;
	localparam logic CFG_SMALL_SPRITE_TBL_HI = 1'b1;

	localparam int SLOT_CAP = 16;

endpackage

### design/sprite_line_evaluation.sv
`timescale 1ns / 1ps
// Write word: accepted while idle, no result; busy stays low.
// Evaluate word: busy through a scan of every entry (one entry read per cycle) and a drain state, then per
// kept sprite a fetch state for its four byte reads and one result state, or one empty result when nothing hits.
// Each result shows on done in the cycle after it is formed;
// the next word is accepted from the cycle the last result shows. The receiver cannot stall.
// Reset clears control state, the configuration and the memory valid bits (memory reads as zero).
module sprite_line_evaluation
	import slev_pkg::*;
#(
	parameter int SPRITE_ENTRIES = 64,
	parameter int LINE_SLOTS     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [7:0]  mem_address,
	input  logic [7:0]  mem_data,
	input  logic [8:0]  line_number,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic        cfg_data,
	output logic        done,
	output logic        found,
	output logic [2:0]  slot,
	output logic [5:0]  sprite_index,
	output logic [7:0]  tile_number,
	output logic [7:0]  attribute_bits,
	output logic [7:0]  x_position,
	output logic [12:0] pattern_address,
	output logic [3:0]  kept_count,
	output logic        overflow,
	output logic        sprite_zero_present,
	output logic        last
);

	localparam int SLOTS = (LINE_SLOTS > SLOT_CAP) ? SLOT_CAP : LINE_SLOTS;
	localparam int EW    = $clog2(SPRITE_ENTRIES);
	localparam int KW    = $clog2(SLOTS + 1);
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	state_t state_q, state_d;

	logic          tall_q;
	logic          tbl_hi_q;
	logic [8:0]    line_q;
	logic [EW-1:0] scan_q;
	logic [EW-1:0] idx_s1;
	logic          cmp_s1;
	logic [KW-1:0] kept_q;
	logic [SW-1:0] emit_q;
	logic [2:0]    byte_q;
	logic          over_q;
	logic          zero_q;
	logic [EW-1:0] sel_q [SLOTS];
	logic [7:0]    y_q, tile_q, attr_q, x_q;

	logic [7:0]    mem_q [256];
	logic [255:0]  vld_q;
	logic [7:0]    rd_raw_q;
	logic          rd_vld_q;
	logic [7:0]    rd_addr;
	logic [7:0]    rd_data;
	logic          mem_we;
	logic          eval_go;

	logic          done_q, found_q, overflow_q, zero_out_q, last_q;
	logic [2:0]    slot_q;
	logic [5:0]    index_q;
	logic [7:0]    tile_out_q, attr_out_q, x_out_q;
	logic [12:0]   pattern_q;
	logic [3:0]    count_q;

	logic [9:0]    scan_diff;
	logic          hit;
	logic [EW-1:0] cur_entry;
	logic [9:0]    emit_diff;
	logic [3:0]    row;
	logic [12:0]   plane_addr;
	logic          emit_last;

	assign busy    = (state_q != ST_IDLE);
	assign mem_we  = start && !busy && (opcode == OP_WRITE);
	assign eval_go = start && !busy && (opcode == OP_EVAL);

	assign cur_entry = sel_q[emit_q];

	always_comb begin
		unique case (state_q)
			ST_SCAN:  rd_addr = 8'({scan_q, 2'b00});
			ST_FETCH: rd_addr = 8'({cur_entry, byte_q[1:0]});
			default:  rd_addr = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_address] <= mem_data;
		end
		rd_raw_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[mem_address] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : 8'd0;

	assign scan_diff = {1'b0, line_q} - {2'b00, rd_data};
	assign hit = !scan_diff[9] && (scan_diff[8:4] == 5'd0) && (tall_q || !scan_diff[3]);

	assign emit_diff = {1'b0, line_q} - {2'b00, y_q};
	assign row = attr_q[7] ? ~emit_diff[3:0] : emit_diff[3:0];
	assign plane_addr = tall_q ? {tile_q[0], tile_q[7:1], row[3], 1'b0, row[2:0]}
	                           : {tbl_hi_q, tile_q, 1'b0, row[2:0]};
	assign emit_last = ((KW'(emit_q) + KW'(1)) == kept_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (eval_go) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_q == EW'(SPRITE_ENTRIES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FETCH;
			end
			ST_FETCH: begin
				if (kept_q == '0) begin
					state_d = ST_IDLE;
				end else if (byte_q == 3'd4) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				state_d = emit_last ? ST_IDLE : ST_FETCH;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tall_q   <= 1'b0;
			tbl_hi_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SPRITE_TALL:         tall_q   <= cfg_data;
				CFG_SMALL_SPRITE_TBL_HI: tbl_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			cmp_s1 <= 1'b0;
			kept_q <= '0;
			emit_q <= '0;
			byte_q <= '0;
			over_q <= 1'b0;
			zero_q <= 1'b0;
		end else begin
			cmp_s1 <= (state_q == ST_SCAN);
			if (eval_go) begin
				scan_q <= '0;
				kept_q <= '0;
				emit_q <= '0;
				byte_q <= '0;
				over_q <= 1'b0;
				zero_q <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				scan_q <= scan_q + EW'(1);
			end
			if (cmp_s1 && hit) begin
				if (idx_s1 == '0) begin
					zero_q <= 1'b1;
				end
				if (kept_q < KW'(SLOTS)) begin
					kept_q <= kept_q + KW'(1);
				end else begin
					over_q <= 1'b1;
				end
			end
			if (state_q == ST_FETCH) begin
				byte_q <= byte_q + 3'd1;
			end
			if (state_q == ST_SEND) begin
				byte_q <= '0;
				emit_q <= emit_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval_go) begin
			line_q <= line_number;
		end
		idx_s1 <= scan_q;
		if (cmp_s1 && hit && (kept_q < KW'(SLOTS))) begin
			sel_q[kept_q[SW-1:0]] <= idx_s1;
		end
		if (state_q == ST_FETCH) begin
			unique case (byte_q)
				3'd1:    y_q    <= rd_data;
				3'd2:    tile_q <= rd_data;
				3'd3:    attr_q <= rd_data;
				3'd4:    x_q    <= rd_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_SEND) || ((state_q == ST_FETCH) && (kept_q == '0));
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SEND) begin
			found_q    <= 1'b1;
			slot_q     <= 3'(emit_q);
			index_q    <= 6'(cur_entry);
			tile_out_q <= tile_q;
			attr_out_q <= attr_q;
			x_out_q    <= x_q;
			pattern_q  <= plane_addr;
			count_q    <= 4'(kept_q);
			overflow_q <= over_q;
			zero_out_q <= zero_q;
			last_q     <= emit_last;
		end else begin
			found_q    <= 1'b0;
			slot_q     <= '0;
			index_q    <= '0;
			tile_out_q <= '0;
			attr_out_q <= '0;
			x_out_q    <= '0;
			pattern_q  <= '0;
			count_q    <= '0;
			overflow_q <= 1'b0;
			zero_out_q <= 1'b0;
			last_q     <= 1'b1;
		end
	end

	assign done                = done_q;
	assign found               = found_q;
	assign slot                = slot_q;
	assign sprite_index        = index_q;
	assign tile_number         = tile_out_q;
	assign attribute_bits      = attr_out_q;
	assign x_position          = x_out_q;
	assign pattern_address     = pattern_q;
	assign kept_count          = count_q;
	assign overflow            = overflow_q;
	assign sprite_zero_present = zero_out_q;
	assign last                = last_q;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb
	import slev_pkg::*;
();

	localparam int ENTRIES = 64;
	localparam int SLOTS   = 8;

	typedef struct packed {
		logic        found;
		logic [2:0]  slot;
		logic [5:0]  sprite_index;
		logic [7:0]  tile_number;
		logic [7:0]  attribute_bits;
		logic [7:0]  x_position;
		logic [12:0] pattern_address;
		logic [3:0]  kept_count;
		logic        overflow;
		logic        sprite_zero_present;
		logic        last;
	} sprite_word_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        opcode;
	logic [7:0]  mem_address;
	logic [7:0]  mem_data;
	logic [8:0]  line_number;
	logic        cfg_write;
	logic        cfg_index;
	logic        cfg_data;
	logic        done;
	logic        found;
	logic [2:0]  slot;
	logic [5:0]  sprite_index;
	logic [7:0]  tile_number;
	logic [7:0]  attribute_bits;
	logic [7:0]  x_position;
	logic [12:0] pattern_address;
	logic [3:0]  kept_count;
	logic        overflow;
	logic        sprite_zero_present;
	logic        last;

	logic [7:0]   attr_mem_image [256];
	logic         tall_mode;
	logic         table_high;
	sprite_word_t pending_words [$];
	int           word_errors;

	sprite_line_evaluation #(
		.SPRITE_ENTRIES(ENTRIES),
		.LINE_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.mem_address(mem_address),
		.mem_data(mem_data),
		.line_number(line_number),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.found(found),
		.slot(slot),
		.sprite_index(sprite_index),
		.tile_number(tile_number),
		.attribute_bits(attribute_bits),
		.x_position(x_position),
		.pattern_address(pattern_address),
		.kept_count(kept_count),
		.overflow(overflow),
		.sprite_zero_present(sprite_zero_present),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		word_errors++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	function automatic void predict_line_words(input logic [8:0] line);
		int unsigned  chosen [$];
		int unsigned  height, hits, y, row, addr, tile, attr, tile_idx, tbl, e, ln;
		bit           zero_hit;
		sprite_word_t w;
		ln = 32'(line);
		height = tall_mode ? 16 : 8;
		hits = 0;
		zero_hit = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			y = 32'(attr_mem_image[(i * 4) % 256]);
			if (ln >= y && ln - y < height) begin
				if (i == 0)
					zero_hit = 1'b1;
				if (chosen.size() < SLOTS)
					chosen.push_back(i);
				hits++;
			end
		end
		if (chosen.size() == 0) begin
			w = '0;
			w.last = 1'b1;
			pending_words.push_back(w);
			return;
		end
		foreach (chosen[k]) begin
			e = chosen[k];
			y = 32'(attr_mem_image[(e * 4) % 256]);
			tile = 32'(attr_mem_image[(e * 4 + 1) % 256]);
			attr = 32'(attr_mem_image[(e * 4 + 2) % 256]);
			row = (ln - y) & 15;
			if (attr[7])
				row = height - 1 - row;
			if (!tall_mode) begin
				addr = (table_high ? 32'h1000 : 32'h0) + tile * 16 + (row & 7);
			end else begin
				tbl = tile[0] ? 32'h1000 : 32'h0;
				tile_idx = tile & 32'hFE;
				if (row >= 8) begin
					tile_idx++;
					row -= 8;
				end
				addr = tbl + tile_idx * 16 + row;
			end
			w.found = 1'b1;
			w.slot = 3'(k);
			w.sprite_index = 6'(e);
			w.tile_number = 8'(tile);
			w.attribute_bits = 8'(attr);
			w.x_position = attr_mem_image[(e * 4 + 3) % 256];
			w.pattern_address = addr[12:0];
			w.kept_count = 4'(chosen.size());
			w.overflow = hits > SLOTS;
			w.sprite_zero_present = zero_hit;
			w.last = (k == chosen.size() - 1);
			pending_words.push_back(w);
		end
	endfunction

	always @(posedge clk) begin : check_words
		sprite_word_t want;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				report_mismatch("result word with nothing pending");
			end else begin
				want = pending_words.pop_front();
				check_field("found", 32'(found), 32'(want.found));
				check_field("slot", 32'(slot), 32'(want.slot));
				check_field("sprite_index", 32'(sprite_index), 32'(want.sprite_index));
				check_field("tile_number", 32'(tile_number), 32'(want.tile_number));
				check_field("attribute_bits", 32'(attribute_bits),
					32'(want.attribute_bits));
				check_field("x_position", 32'(x_position), 32'(want.x_position));
				check_field("pattern_address", 32'(pattern_address),
					32'(want.pattern_address));
				check_field("kept_count", 32'(kept_count), 32'(want.kept_count));
				check_field("overflow", 32'(overflow), 32'(want.overflow));
				check_field("sprite_zero_present", 32'(sprite_zero_present),
					32'(want.sprite_zero_present));
				check_field("last", 32'(last), 32'(want.last));
			end
		end
	end

	task automatic send_word(input logic op, input logic [7:0] addr, input logic [7:0] data,
			input logic [8:0] line);
		@(negedge clk);
		start <= 1'b1;
		opcode <= op;
		mem_address <= addr;
		mem_data <= data;
		line_number <= line;
		do
			@(posedge clk);
		while (busy);
		if (op == OP_WRITE)
			attr_mem_image[addr] = data;
		else
			predict_line_words(line);
	endtask

	task automatic send_eval(input logic [8:0] line);
		send_word(OP_EVAL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), line);
	endtask

	task automatic send_entry(input int entry, input logic [7:0] y, input logic [7:0] tile,
			input logic [7:0] attr, input logic [7:0] x);
		send_word(OP_WRITE, 8'(entry * 4), y, 9'($urandom_range(0, 511)));
		send_word(OP_WRITE, 8'(entry * 4 + 1), tile, 9'($urandom_range(0, 511)));
		send_word(OP_WRITE, 8'(entry * 4 + 2), attr, 9'($urandom_range(0, 511)));
		send_word(OP_WRITE, 8'(entry * 4 + 3), x, 9'($urandom_range(0, 511)));
	endtask

	task automatic hold_idle(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic set_mode(input logic tall, input logic hi);
		hold_idle(1);
		while (pending_words.size() != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_SPRITE_TALL;
		cfg_data <= tall;
		@(negedge clk);
		cfg_index <= CFG_SMALL_SPRITE_TBL_HI;
		cfg_data <= hi;
		@(negedge clk);
		cfg_write <= 1'b0;
		tall_mode = tall;
		table_high = hi;
	endtask

	task automatic test_cleared_memory();
		send_eval(9'd0);
		send_eval(9'd7);
		send_eval(9'd8);
		send_eval(9'd511);
	endtask

	task automatic test_edge_entries();
		send_entry(0, 8'hFF, 8'hFF, 8'h80, 8'hFF);
		send_entry(63, 8'd200, 8'h00, 8'h7F, 8'h00);
		send_eval(9'd255);
		send_eval(9'd262);
		send_eval(9'd263);
		send_eval(9'd200);
		send_eval(9'd207);
	endtask

	task automatic test_tall_sprites();
		set_mode(1'b1, 1'b1);
		send_eval(9'd270);
		send_eval(9'd256);
		send_eval(9'd15);
		send_eval(9'd215);
		set_mode(1'b0, 1'b1);
		send_eval(9'd0);
	endtask

	task automatic test_random_traffic(input int count);
		int          burst_left;
		int unsigned window_base;
		logic [7:0]  addr;
		logic [7:0]  data;
		burst_left = $urandom_range(1, 20);
		window_base = $urandom_range(0, 250);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 31) == 0)
				window_base = $urandom_range(0, 250);
			if ($urandom_range(0, 99) < 55) begin
				addr = 8'($urandom_range(0, 255));
				data = 8'($urandom_range(0, 255));
				if (addr[1:0] == 2'd0 && $urandom_range(0, 3) != 0)
					data = 8'((window_base + $urandom_range(0, 15)) % 256);
				send_word(OP_WRITE, addr, data, 9'($urandom_range(0, 511)));
			end else if ($urandom_range(0, 9) == 0) begin
				send_eval(9'($urandom_range(0, 511)));
			end else begin
				send_eval(9'(window_base + $urandom_range(0, 20)));
			end
			burst_left--;
			if (burst_left == 0) begin
				hold_idle($urandom_range(1, 12));
				burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 20);
			end
		end
	endtask

	initial begin : run_tests
		int drain_cycles;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_WRITE;
		mem_address = '0;
		mem_data = '0;
		line_number = '0;
		cfg_write = 1'b0;
		cfg_index = CFG_SPRITE_TALL;
		cfg_data = 1'b0;
		tall_mode = 1'b0;
		table_high = 1'b0;
		word_errors = 0;
		foreach (attr_mem_image[i])
			attr_mem_image[i] = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_cleared_memory();
		test_edge_entries();
		test_tall_sprites();

		set_mode(1'b0, 1'b0);
		test_random_traffic(103);
		set_mode(1'b0, 1'b1);
		test_random_traffic(103);
		set_mode(1'b1, 1'b1);
		test_random_traffic(102);
		set_mode(1'b1, 1'b0);
		test_random_traffic(102);

		hold_idle(1);
		drain_cycles = 0;
		while (pending_words.size() != 0 && drain_cycles < 20000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (150) @(posedge clk);
		if (pending_words.size() != 0)
			report_mismatch($sformatf("%0d expected words never arrived",
				pending_words.size()));
		if (word_errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
